@@ hdl/length_prefix_to_start_code_unit_defines.svh @@
// Assertion macros shared by the length-prefix to start-code unit.
// No dependencies; included by the modules that carry assertions.
`ifndef LENGTH_PREFIX_TO_START_CODE_UNIT_DEFINES_SVH
`define LENGTH_PREFIX_TO_START_CODE_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
// Antecedent implies consequent in the same cycle
`define LPSC_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lpsc: same-cycle check failed");
// Antecedent implies consequent in the next cycle
`define LPSC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lpsc: next-cycle check failed");
`else
`define LPSC_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define LPSC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

@@ hdl/lpsc_pkg.sv @@
// Types and constants of the length-prefix to start-code unit.
// No dependencies; imported by every module of the unit.
package lpsc_pkg;

    // Result kind carried on the output tuser
    typedef enum logic [1:0] {
        KIND_PAYLOAD = 2'd0,
        KIND_START   = 2'd1,
        KIND_ERROR   = 2'd2
    } t_kind;

    // Results caused by one input byte, handed from parser to emitter
    typedef struct packed {
        logic       has_payload;
        logic       has_start;
        logic       has_error;
        logic [7:0] data;
    } t_bundle;

    localparam logic [2:0] PREFIX_MIN     = 3'd1;
    localparam logic [2:0] PREFIX_MAX     = 3'd4;
    localparam logic [2:0] LFB_RESET      = 3'd4;
    localparam logic       REG_LFB        = 1'b0;
    localparam logic [7:0] START_CODE_END = 8'h01;
    localparam logic [1:0] START_LAST_IDX = 2'd2;

    // Clamp the register to a usable prefix length
    function automatic logic [2:0] prefix_len(input logic [2:0] cfg);
        logic [2:0] len;
        if (cfg < PREFIX_MIN) begin
            len = PREFIX_MIN;
        end else if (cfg > PREFIX_MAX) begin
            len = PREFIX_MAX;
        end else begin
            len = cfg;
        end
        return len;
    endfunction

endpackage

@@ hdl/lpsc_parse.sv @@
// Input register and length/payload parser of the unit.
// Depends on lpsc_pkg and the unit's assertion macro header.
`include "length_prefix_to_start_code_unit_defines.svh"

module lpsc_parse #(
    parameter int LEN_BITS = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [7:0]        i_byte,
    input  logic              i_last,
    output logic              o_ready,
    input  logic [2:0]        i_prefix_len,
    input  logic              i_free,
    output logic              o_load,
    output lpsc_pkg::t_bundle o_bundle
);
    import lpsc_pkg::*;

    localparam logic [LEN_BITS-1:0] LenOne  = {{(LEN_BITS-1){1'b0}}, 1'b1};
    localparam logic [LEN_BITS-1:0] LenZero = '0;

    logic                r_in_valid;
    logic [7:0]          r_in_byte;
    logic                r_in_last;
    logic                r_in_payload, n_in_payload;
    logic [1:0]          r_seen, n_seen;
    logic [LEN_BITS-1:0] r_acc, n_acc;
    logic [LEN_BITS-1:0] r_remaining, n_remaining;
    logic [LEN_BITS+7:0] shifted;
    logic [LEN_BITS-1:0] acc_next;
    logic                has_payload, has_start, has_error;

    // Input register takes a byte whenever it is empty or moving on
    assign o_load  = r_in_valid && i_free;
    assign o_ready = !r_in_valid || o_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_in_byte <= i_byte;
            r_in_last <= i_last;
        end
    end

    // Length accumulation keeps the low LEN_BITS bits
    assign shifted  = {r_acc, r_in_byte};
    assign acc_next = shifted[LEN_BITS-1:0];

    // Next state and result set for the registered byte
    always_comb begin
        n_in_payload = r_in_payload;
        n_seen       = r_seen;
        n_acc        = r_acc;
        n_remaining  = r_remaining;
        has_payload  = 1'b0;
        has_start    = 1'b0;
        has_error    = 1'b0;
        if (r_in_payload) begin
            has_payload = 1'b1;
            n_remaining = r_remaining - LenOne;
            if (r_remaining == LenOne) begin
                n_in_payload = 1'b0;
            end
        end else if (({1'b0, r_seen} + 3'd1) >= i_prefix_len) begin
            // length field complete: start code, then payload if nonzero
            has_start = 1'b1;
            if (acc_next != LenZero) begin
                n_in_payload = 1'b1;
                n_remaining  = acc_next;
            end
            n_seen = 2'd0;
            n_acc  = LenZero;
        end else begin
            n_seen = r_seen + 2'd1;
            n_acc  = acc_next;
        end
        // extent end: flag truncation and resynchronize
        if (r_in_last) begin
            has_error    = n_in_payload || (n_seen != 2'd0);
            n_in_payload = 1'b0;
            n_seen       = 2'd0;
            n_acc        = LenZero;
            n_remaining  = LenZero;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_payload <= 1'b0;
            r_seen       <= 2'd0;
            r_acc        <= LenZero;
            r_remaining  <= LenZero;
        end else if (o_load) begin
            r_in_payload <= n_in_payload;
            r_seen       <= n_seen;
            r_acc        <= n_acc;
            r_remaining  <= n_remaining;
        end
    end

    assign o_bundle.has_payload = has_payload;
    assign o_bundle.has_start   = has_start;
    assign o_bundle.has_error   = has_error;
    assign o_bundle.data        = r_in_byte;

    // Payload mode always has bytes left to pass
    `LPSC_ASSERT_NOW(a_payload_nonzero, i_clk, i_rst_n, r_in_payload, r_remaining != LenZero)
    // An extent end leaves the parser at the start of a length field
    `LPSC_ASSERT_NEXT(a_end_resync, i_clk, i_rst_n, o_load && r_in_last,
                      !r_in_payload && (r_seen == 2'd0) && (r_acc == LenZero))

endmodule

@@ hdl/lpsc_emit.sv @@
// Result register and serializer: one result of the current set per cycle while i_tready is high.
// Depends on lpsc_pkg and the unit's assertion macro header.
`include "length_prefix_to_start_code_unit_defines.svh"

module lpsc_emit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  lpsc_pkg::t_bundle i_bundle,
    output logic              o_free,
    output logic              o_tvalid,
    input  logic              i_tready,
    output logic [7:0]        o_tdata,
    output lpsc_pkg::t_kind   o_tuser,
    output logic              o_tlast
);
    import lpsc_pkg::*;

    t_bundle    r_bundle;
    logic       r_valid;
    logic [1:0] r_idx;
    logic [2:0] count;
    logic [2:0] load_count;
    logic       at_last;

    function automatic logic [2:0] result_count(input t_bundle b);
        logic [2:0] n;
        if (b.has_payload) begin
            n = 3'd1;
        end else if (b.has_start) begin
            n = 3'd3;
        end else begin
            n = 3'd0;
        end
        return n + {2'b00, b.has_error};
    endfunction

    assign count      = result_count(r_bundle);
    assign load_count = result_count(i_bundle);
    assign at_last    = ({1'b0, r_idx} == (count - 3'd1));
    assign o_free     = !r_valid || (i_tready && at_last);

    // Walk the stored set; a new set loads as the last result leaves
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 2'd0;
        end else if (o_free) begin
            r_valid <= i_load && (load_count != 3'd0);
            r_idx   <= 2'd0;
        end else if (i_tready) begin
            r_idx <= r_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_load) begin
            r_bundle <= i_bundle;
        end
    end

    // Result at the current position
    always_comb begin
        o_tuser = KIND_ERROR;
        o_tdata = 8'h00;
        if (r_bundle.has_payload) begin
            if (r_idx == 2'd0) begin
                o_tuser = KIND_PAYLOAD;
                o_tdata = r_bundle.data;
            end
        end else if (r_bundle.has_start) begin
            if (r_idx <= START_LAST_IDX) begin
                o_tuser = KIND_START;
                o_tdata = (r_idx == START_LAST_IDX) ? START_CODE_END : 8'h00;
            end
        end
    end

    assign o_tvalid = r_valid;
    assign o_tlast  = at_last;

    // Position never runs past the set
    `LPSC_ASSERT_NOW(a_idx_in_range, i_clk, i_rst_n, r_valid, {1'b0, r_idx} < count)
    // A set never mixes a payload byte with a start code
    `LPSC_ASSERT_NOW(a_set_shape, i_clk, i_rst_n, r_valid,
                     !(r_bundle.has_payload && r_bundle.has_start))

endmodule

@@ hdl/length_prefix_to_start_code_unit.sv @@
// Top level of the length-prefix to start-code unit: APB register, parser, emitter.
// Depends on lpsc_pkg, lpsc_parse and lpsc_emit.
//
//  channel | dir | handshake              | content
//  s_*     | in  | s_tvalid / s_tready    | tdata: in_byte; tlast: extent_end
//  m_*     | out | m_tvalid / m_tready    | tdata: out_byte; tuser: kind; tlast: run_last
//  apb     | in  | psel & penable, pready | reg 0 @ 0x0: length_field_bytes [2:0]
//
//  Each payload byte gives one result, two if it also truncates the extent; a lone
//  truncation gives one, and a byte inside a length field gives none. A byte that
//  completes a length field gives three start-code results (four if it also
//  truncates the extent): the result serializer sends one result per cycle while
//  m_tready is high. Each byte passes the input register, then the result register.
//  Reset is synchronous; no clearing pass. A low m_tready holds the result and
//  backs up into s_tready once the input register is full.
module length_prefix_to_start_code_unit #(
    parameter int LEN_BITS = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // input stream
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_byte
    input  logic       s_tlast,
    // output stream
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic [1:0] m_tuser,   // [1:0] result_kind
    output logic       m_tlast,
    // configuration
    input  logic       psel,
    input  logic       penable,
    input  logic       pwrite,
    input  logic [2:0] paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic       pready
);
    import lpsc_pkg::*;

    logic       lfb_sel;
    logic [2:0] r_length_field_bytes;
    logic       load;
    logic       free;
    t_bundle    bundle;
    t_kind      kind;

    // Register write on the access cycle
    assign pready  = 1'b1;
    assign lfb_sel = (paddr[2] == REG_LFB);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_length_field_bytes <= LFB_RESET;
        end else if (psel && penable && pwrite && pready && lfb_sel) begin
            r_length_field_bytes <= pwdata[2:0];
        end
    end

    assign prdata = lfb_sel ? {29'd0, r_length_field_bytes} : 32'd0;

    lpsc_parse #(
        .LEN_BITS (LEN_BITS)
    ) u_parse (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (s_tvalid),
        .i_byte       (s_tdata),
        .i_last       (s_tlast),
        .o_ready      (s_tready),
        .i_prefix_len (prefix_len(r_length_field_bytes)),
        .i_free       (free),
        .o_load       (load),
        .o_bundle     (bundle)
    );

    lpsc_emit u_emit (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (load),
        .i_bundle (bundle),
        .o_free   (free),
        .o_tvalid (m_tvalid),
        .i_tready (m_tready),
        .o_tdata  (m_tdata),
        .o_tuser  (kind),
        .o_tlast  (m_tlast)
    );

    assign m_tuser = kind;

endmodule

@@ sim/length_prefix_to_start_code_unit_tb.sv @@
// Self-checking testbench of the length-prefix to start-code unit: stream driver, receiver,
// byte-level converter predictor and result checker, APB register writes between phases.
// Depends on lpsc_pkg and length_prefix_to_start_code_unit.
`timescale 1ns / 100ps

module length_prefix_to_start_code_unit_tb;
    import lpsc_pkg::*;

    localparam int         LEN_BITS    = 32;
    localparam logic [2:0] LFB_ADDR    = 3'(4 * REG_LFB);
    localparam int         HOLD_CYCLES = 250;
    localparam int         SETTLE      = 8;

    // one input transaction
    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_ext_byte;

    // one output transaction
    typedef struct packed {
        logic [7:0] data;
        t_kind      kind;
        logic       last;
    } t_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = 3'd0;
    logic [31:0] pwdata = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    length_prefix_to_start_code_unit #(
        .LEN_BITS (LEN_BITS)
    ) uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // bytes waiting to be offered, and the start-code stream expected back
    t_ext_byte extent_q[$];
    t_result   annexb_q[$];

    int errors = 0;
    int results_seen = 0;
    bit no_idle = 1'b0;

    // converter model state
    logic [2:0]          lfb_cfg = LFB_RESET;
    logic                in_nal_payload = 1'b0;
    logic [1:0]          prefix_seen = 2'd0;
    logic [LEN_BITS-1:0] nal_len_acc = '0;
    logic [LEN_BITS-1:0] payload_left = '0;

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // register value out of range is clamped to 1..4
    function automatic int unsigned eff_prefix(input logic [2:0] cfg);
        if (cfg == 3'd0) return 1;
        if (cfg > 3'd4) return 4;
        return int'(cfg);
    endfunction

    function automatic int unsigned gap_draw();
        if (no_idle) return 0;
        return $urandom_range(0, 3);
    endfunction

    // advance the converter model by one extent byte, queue what it emits
    function automatic void convert_byte(input logic [7:0] b, input logic eoe);
        t_result r[4];
        int      n;
        int      i;
        n = 0;
        if (in_nal_payload) begin
            r[n] = '{b, KIND_PAYLOAD, 1'b0};
            n++;
            payload_left = payload_left - 1'b1;
            if (payload_left == '0) in_nal_payload = 1'b0;
        end else begin
            nal_len_acc = (nal_len_acc << 8) | LEN_BITS'(b);
            if (int'(prefix_seen) + 1 >= eff_prefix(lfb_cfg)) begin
                r[0] = '{8'h00, KIND_START, 1'b0};
                r[1] = '{8'h00, KIND_START, 1'b0};
                r[2] = '{START_CODE_END, KIND_START, 1'b0};
                n = 3;
                if (nal_len_acc != '0) begin
                    in_nal_payload = 1'b1;
                    payload_left = nal_len_acc;
                end
                prefix_seen = 2'd0;
                nal_len_acc = '0;
            end else begin
                prefix_seen = prefix_seen + 1'b1;
            end
        end
        // extent end: truncation check and resync
        if (eoe) begin
            if (in_nal_payload || prefix_seen != 2'd0) begin
                r[n] = '{8'h00, KIND_ERROR, 1'b0};
                n++;
            end
            in_nal_payload = 1'b0;
            prefix_seen = 2'd0;
            nal_len_acc = '0;
            payload_left = '0;
        end
        for (i = 0; i < n; i++) begin
            r[i].last = (i == n - 1);
            annexb_q.insert(annexb_q.size(), r[i]);
        end
    endfunction

    // stream driver
    always @(posedge i_clk) begin : drv
        int unsigned send_wait;
        t_ext_byte   nxt;
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
            send_wait = 0;
        end else if (!s_tvalid || s_tready) begin
            if (send_wait != 0) begin
                send_wait = send_wait - 1;
                s_tvalid <= 1'b0;
            end else if (extent_q.size() != 0) begin
                nxt = extent_q.pop_front();
                s_tdata <= nxt.data;
                s_tlast <= nxt.last;
                s_tvalid <= 1'b1;
                send_wait = gap_draw();
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // result receiver, with one long hold-off to back the block up
    always @(posedge i_clk) begin : rcv
        int unsigned rdy_wait;
        int unsigned hold_cnt;
        int unsigned w;
        bit          held;
        if (!i_rst_n) begin
            m_tready <= 1'b0;
            rdy_wait = 0;
            hold_cnt = 0;
            held = 1'b0;
        end else if (!held && results_seen >= 60 && extent_q.size() > 20) begin
            held = 1'b1;
            hold_cnt = HOLD_CYCLES;
            m_tready <= 1'b0;
        end else if (hold_cnt != 0) begin
            hold_cnt = hold_cnt - 1;
            m_tready <= 1'b0;
        end else if (m_tvalid && m_tready) begin
            w = gap_draw();
            rdy_wait = w;
            m_tready <= (w == 0);
        end else if (rdy_wait != 0) begin
            rdy_wait = rdy_wait - 1;
            m_tready <= (rdy_wait == 0);
        end else begin
            m_tready <= 1'b1;
        end
    end

    // monitor: predict on input transaction, compare on output transaction
    always @(posedge i_clk) begin : mon
        t_result want;
        if (i_rst_n) begin
            if (s_tvalid && s_tready) convert_byte(s_tdata, s_tlast);
            if (m_tvalid && m_tready) begin
                results_seen <= results_seen + 1;
                if (annexb_q.size() == 0) begin
                    $error("unexpected result: out_byte %0h kind %0d run_last %0b",
                           m_tdata, m_tuser, m_tlast);
                    errors++;
                end else begin
                    want = annexb_q.pop_front();
                    if (m_tdata !== want.data) begin
                        $error("out_byte: expected %0h, actual %0h", want.data, m_tdata);
                        errors++;
                    end
                    if (m_tuser !== want.kind) begin
                        $error("result_kind: expected %0d, actual %0d", want.kind, m_tuser);
                        errors++;
                    end
                    if (m_tlast !== want.last) begin
                        $error("run_last: expected %0b, actual %0b", want.last, m_tlast);
                        errors++;
                    end
                end
            end
        end
    end

    // APB write of the prefix length register, then read it back
    task automatic write_lfb(input logic [2:0] v);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= LFB_ADDR;
        pwdata <= {29'd0, v};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        lfb_cfg = v;
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        psel <= 1'b1;
        pwrite <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (prdata[2:0] !== v) begin
            $error("length_field_bytes: expected %0d, actual %0d", v, prdata[2:0]);
            errors++;
        end
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    // wait until every byte is taken and every result is back, then let the pipe settle
    task automatic wait_idle();
        do @(negedge i_clk);
        while (extent_q.size() != 0 || s_tvalid || annexb_q.size() != 0);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic push_byte(input logic [7:0] b, input logic eoe);
        extent_q.insert(extent_q.size(), t_ext_byte'{b, eoe});
    endtask

    function automatic int unsigned pick_len(input int unsigned plen);
        int unsigned r;
        r = $urandom_range(0, 19);
        if (r < 3) return 0;
        if (r < 17) return $urandom_range(1, 8);
        return $urandom_range(9, (plen == 1) ? 40 : 60);
    endfunction

    // one extent: mostly well-formed NAL units, some truncated, some noise
    task automatic add_extent(input int unsigned plen, inout int unsigned added);
        t_ext_byte   ext[$];
        int unsigned r;
        int unsigned n_nal;
        int unsigned len;
        int unsigned cut;
        int unsigned i;
        int unsigned j;
        int          k;
        logic [31:0] lv;
        bit          huge;
        huge = 1'b0;
        r = $urandom_range(0, 19);
        if (r < 2) begin
            len = $urandom_range(1, 6);
            for (i = 0; i < len; i++) ext.insert(ext.size(), t_ext_byte'{8'($urandom), 1'b0});
        end else begin
            n_nal = $urandom_range(1, 3);
            for (i = 0; i < n_nal && !huge; i++) begin
                if ($urandom_range(0, 24) == 0) begin
                    // all-ones length, extent ends well before the payload does
                    huge = 1'b1;
                    lv = '1;
                    len = $urandom_range(0, 4);
                end else begin
                    len = pick_len(plen);
                    lv = len;
                end
                for (k = int'(plen) - 1; k >= 0; k--)
                    ext.insert(ext.size(), t_ext_byte'{lv[8*k +: 8], 1'b0});
                for (j = 0; j < len; j++)
                    ext.insert(ext.size(), t_ext_byte'{8'($urandom), 1'b0});
            end
        end
        cut = ext.size();
        if (!huge && r >= 17) cut = $urandom_range(1, ext.size());
        for (i = 0; i < cut; i++) push_byte(ext[i].data, i == cut - 1);
        added += cut;
    endtask

    task automatic random_phase(input int unsigned n_items);
        int unsigned added;
        added = 0;
        @(negedge i_clk);
        no_idle = ($urandom_range(0, 3) == 0);
        while (added < n_items) add_extent(eff_prefix(lfb_cfg), added);
    endtask

    // main sequence
    initial begin : seq
        logic [2:0] cfg_list[8];
        int         p;
        cfg_list = '{3'd1, 3'd2, 3'd3, 3'd0, 3'd7, 3'd5, 3'd6, 3'd4};
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed, 4-byte prefix after reset
        // zero length, then a 2-byte NAL with a clean extent end
        push_byte(8'h00, 1'b0); push_byte(8'h00, 1'b0);
        push_byte(8'h00, 1'b0); push_byte(8'h00, 1'b0);
        push_byte(8'h00, 1'b0); push_byte(8'h00, 1'b0);
        push_byte(8'h00, 1'b0); push_byte(8'h02, 1'b0);
        push_byte(8'hAA, 1'b0); push_byte(8'h55, 1'b1);
        // extent cut inside the length field
        push_byte(8'hFF, 1'b0); push_byte(8'hFF, 1'b1);
        // maximum length, extent cut inside the payload
        push_byte(8'hFF, 1'b0); push_byte(8'hFF, 1'b0);
        push_byte(8'hFF, 1'b0); push_byte(8'hFF, 1'b0);
        push_byte(8'h00, 1'b0); push_byte(8'hFF, 1'b1);
        // length completes on the last byte: start code plus truncation
        push_byte(8'h00, 1'b0); push_byte(8'h00, 1'b0);
        push_byte(8'h00, 1'b0); push_byte(8'h07, 1'b1);

        random_phase(26);
        for (p = 0; p < 8; p++) begin
            wait_idle();
            write_lfb(cfg_list[p]);
            random_phase(26);
        end
        wait_idle();

        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // watchdog
    initial begin
        #2000000;
        $display("status: fail");
        $finish;
    end

endmodule

@@ length_prefix_to_start_code_unit.f @@
+incdir+hdl
hdl/lpsc_pkg.sv
hdl/lpsc_parse.sv
hdl/lpsc_emit.sv
hdl/length_prefix_to_start_code_unit.sv
sim/length_prefix_to_start_code_unit_tb.sv
